### sv/rastz_pkg.sv
// Shared types and constants for the range-add segment tree block.
package rastz_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_VALUE_BITS   = 16;

  localparam int          SIZE_BITS  = 11;
  localparam logic [10:0] SIZE_RESET = 11'd1024;

  // Register index as seen in bit 2 of the APB byte address.
  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ADD    = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_MIN = 2'd1,
    ALU_MAX = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic min_en;
    logic max_en;
    logic pend_en;
  } mem_wen_t;

  typedef struct packed {
    logic busy;
    logic clearing;
  } seq_status_t;

endpackage

### sv/rastz_alu.sv
// Shared saturating adder and min/max compare unit.
module rastz_alu #(
  parameter int VALUE_BITS = rastz_pkg::DEF_VALUE_BITS
) (
  input  rastz_pkg::alu_op_t                                    op,
  input  logic signed [((VALUE_BITS > 16) ? VALUE_BITS : 16):0] a,
  input  logic signed [((VALUE_BITS > 16) ? VALUE_BITS : 16):0] b,
  output logic signed [VALUE_BITS-1:0]                          y
);
  import rastz_pkg::*;

  localparam int AW = ((VALUE_BITS > 16) ? VALUE_BITS : 16) + 1;
  localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

  logic signed [AW-1:0] sum;

  assign sum = a + b;

  always_comb begin
    unique case (op)
      ALU_ADD: begin
        if (sum > SAT_HI) y = SAT_HI[VALUE_BITS-1:0];
        else if (sum < SAT_LO) y = SAT_LO[VALUE_BITS-1:0];
        else y = sum[VALUE_BITS-1:0];
      end
      ALU_MIN: y = (a < b) ? a[VALUE_BITS-1:0] : b[VALUE_BITS-1:0];
      ALU_MAX: y = (a > b) ? a[VALUE_BITS-1:0] : b[VALUE_BITS-1:0];
      default: y = sum[VALUE_BITS-1:0];
    endcase
  end

endmodule

### sv/rastz_node_mem.sv
// Node storage: minimum, maximum and pending add, one read and one write port.
module rastz_node_mem #(
  parameter int MAX_ELEMENTS = rastz_pkg::DEF_MAX_ELEMENTS,
  parameter int VALUE_BITS   = rastz_pkg::DEF_VALUE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rd_en,
  input  logic [$clog2(4*MAX_ELEMENTS)-1:0]        rd_addr,
  input  logic [$clog2(4*MAX_ELEMENTS)-1:0]        wr_addr,
  input  rastz_pkg::mem_wen_t                      wen,
  input  logic signed [VALUE_BITS-1:0]             wr_data,
  output logic signed [VALUE_BITS-1:0]             q_min,
  output logic signed [VALUE_BITS-1:0]             q_max,
  output logic signed [VALUE_BITS-1:0]             q_pend
);
  import rastz_pkg::*;

  localparam int NODES = 4 * MAX_ELEMENTS;

  logic [VALUE_BITS-1:0] min_mem  [NODES];
  logic [VALUE_BITS-1:0] max_mem  [NODES];
  logic [VALUE_BITS-1:0] pend_mem [NODES];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_min  <= min_mem[rd_addr];
      q_max  <= max_mem[rd_addr];
      q_pend <= pend_mem[rd_addr];
    end
    if (wen.min_en)  min_mem[wr_addr]  <= wr_data;
    if (wen.max_en)  max_mem[wr_addr]  <= wr_data;
    if (wen.pend_en) pend_mem[wr_addr] <= wr_data;
  end

endmodule

### sv/rastz_seq.sv
// Sequencer that walks the tree with an explicit frame stack.
module rastz_seq #(
  parameter int MAX_ELEMENTS = rastz_pkg::DEF_MAX_ELEMENTS,
  parameter int VALUE_BITS   = rastz_pkg::DEF_VALUE_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   start,
  input  logic [1:0]                                             in_operation,
  input  logic [9:0]                                             in_low_index,
  input  logic [9:0]                                             in_high_index,
  input  logic signed [15:0]                                     in_amount,
  input  logic [rastz_pkg::SIZE_BITS-1:0]                        size_cfg,
  output rastz_pkg::seq_status_t                                 status,
  output logic                                                   out_strobe,
  output logic                                                   out_found,
  output logic [9:0]                                             out_position,
  output logic                                                   rd_en,
  output logic [$clog2(4*MAX_ELEMENTS)-1:0]                      rd_addr,
  output logic [$clog2(4*MAX_ELEMENTS)-1:0]                      wr_addr,
  output rastz_pkg::mem_wen_t                                    wen,
  output logic signed [VALUE_BITS-1:0]                           wr_data,
  input  logic signed [VALUE_BITS-1:0]                           q_min,
  input  logic signed [VALUE_BITS-1:0]                           q_max,
  input  logic signed [VALUE_BITS-1:0]                           q_pend,
  output rastz_pkg::alu_op_t                                     alu_op,
  output logic signed [((VALUE_BITS > 16) ? VALUE_BITS : 16):0]  alu_a,
  output logic signed [((VALUE_BITS > 16) ? VALUE_BITS : 16):0]  alu_b,
  input  logic signed [VALUE_BITS-1:0]                           alu_y
);
  import rastz_pkg::*;

  localparam int IW    = $clog2(MAX_ELEMENTS);
  localparam int KW    = $clog2(4 * MAX_ELEMENTS);
  localparam int AW    = ((VALUE_BITS > 16) ? VALUE_BITS : 16) + 1;
  localparam int SD    = IW + 1;
  localparam int SIW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int SPW   = $clog2(SD + 1);
  localparam int FW    = KW + 2 * IW + 1;
  localparam logic [KW-1:0] LAST_NODE = KW'(4 * MAX_ELEMENTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LEAF, S_LEAF_WR, S_ENTER, S_FIND_CHK, S_PD_RD,
    S_AP_MIN, S_AP_MAX, S_AP_PEND, S_PD_CLR, S_DESCEND, S_RESUME,
    S_PU_A, S_PU_MIN, S_PU_MAX, S_RET
  } state_t;

  typedef enum logic [1:0] {AP_TOP, AP_LEFT, AP_RIGHT} ap_sel_t;
  typedef enum logic {PH_AFTER_FIRST, PH_AFTER_SECOND} phase_t;

  state_t                 state_r;
  op_t                    op_r;
  ap_sel_t                ap_sel_r;
  phase_t                 ph_r;
  logic [KW-1:0]          k_r, ap_node_r, clr_r;
  logic [IW-1:0]          l_r, r_r, ql_r, qr_r, got_r;
  logic                   got_v_r;
  logic [SPW-1:0]         sp_r;
  logic [FW-1:0]          stk_r [SD];
  logic signed [AW-1:0]   amt_r, d_r;
  logic signed [VALUE_BITS-1:0] hold_min_r, hold_max_r;
  logic                   out_strobe_r, out_found_r;
  logic [9:0]             out_position_r;

  logic [KW-1:0]  kl, kr;
  logic [IW:0]    lr_sum;
  logic [IW-1:0]  mid, mid_p1;
  logic [SPW-1:0] sp_m1;
  logic [31:0]    size32, n32, lo32, hi32, top32;
  logic signed [AW-1:0] amount_ext;

  function automatic logic signed [AW-1:0] ext_v(input logic signed [VALUE_BITS-1:0] x);
    return {{(AW-VALUE_BITS){x[VALUE_BITS-1]}}, x};
  endfunction

  assign kl     = {k_r[KW-2:0], 1'b0};
  assign kr     = {k_r[KW-2:0], 1'b1};
  assign lr_sum = {1'b0, l_r} + {1'b0, r_r};
  assign mid    = lr_sum[IW:1];
  assign mid_p1 = mid + IW'(1);
  assign sp_m1  = sp_r - SPW'(1);

  assign amount_ext = {{(AW-16){in_amount[15]}}, in_amount};
  assign size32 = 32'(size_cfg);
  assign n32    = (size32 == 32'd0) ? 32'd1 :
                  ((size32 > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : size32);
  assign lo32   = 32'(in_low_index);
  assign hi32   = 32'(in_high_index);
  assign top32  = (hi32 < n32 - 32'd1) ? hi32 : n32 - 32'd1;

  assign status.busy     = (state_r != S_IDLE);
  assign status.clearing = (state_r == S_CLEAR);
  assign out_strobe   = out_strobe_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  // Memory and shared unit steering follows the current step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k_r;
    wr_addr = k_r;
    wen     = '0;
    wr_data = alu_y;
    alu_op  = ALU_ADD;
    alu_a   = ext_v(q_min);
    alu_b   = d_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_addr = clr_r;
        wen     = '{min_en: 1'b1, max_en: 1'b1, pend_en: 1'b1};
        wr_data = '0;
      end
      S_LEAF_WR: begin
        alu_a = d_r;
        alu_b = '0;
        wen   = '{min_en: 1'b1, max_en: 1'b1, pend_en: 1'b0};
      end
      S_ENTER: begin
        rd_en = 1'b1;
        if (op_r == OP_BUILD) begin
          wen.pend_en = 1'b1;
          wr_data     = '0;
        end
      end
      S_PD_RD: begin
        rd_addr = kl;
        rd_en   = (q_pend != '0);
      end
      S_AP_MIN: begin
        wr_addr    = ap_node_r;
        wen.min_en = 1'b1;
      end
      S_AP_MAX: begin
        wr_addr    = ap_node_r;
        alu_a      = ext_v(q_max);
        wen.max_en = 1'b1;
      end
      S_AP_PEND: begin
        wr_addr     = ap_node_r;
        alu_a       = ext_v(q_pend);
        wen.pend_en = 1'b1;
        rd_addr     = kr;
        rd_en       = (ap_sel_r == AP_LEFT);
      end
      S_PD_CLR: begin
        wen.pend_en = 1'b1;
        wr_data     = '0;
      end
      S_RESUME: begin
        rd_addr = kl;
        rd_en   = (op_r != OP_SEARCH) && (ph_r == PH_AFTER_SECOND);
      end
      S_PU_A: begin
        rd_addr = kr;
        rd_en   = 1'b1;
      end
      S_PU_MIN: begin
        alu_op     = ALU_MIN;
        alu_a      = ext_v(hold_min_r);
        alu_b      = ext_v(q_min);
        wen.min_en = 1'b1;
      end
      S_PU_MAX: begin
        alu_op     = ALU_MAX;
        alu_a      = ext_v(hold_max_r);
        alu_b      = ext_v(q_max);
        wen.max_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      sp_r         <= '0;
      got_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + KW'(1);
          if (clr_r == LAST_NODE) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r    <= op_t'(in_operation);
            amt_r   <= amount_ext;
            d_r     <= amount_ext;
            sp_r    <= '0;
            k_r     <= KW'(1);
            l_r     <= '0;
            r_r     <= IW'(n32 - 32'd1);
            got_v_r <= 1'b0;
            ql_r    <= IW'(lo32);
            qr_r    <= IW'(top32);
            unique case (op_t'(in_operation))
              OP_WRITE: begin
                if (lo32 < n32) state_r <= S_LEAF;
                else begin
                  out_strobe_r   <= 1'b1;
                  out_found_r    <= 1'b0;
                  out_position_r <= '0;
                end
              end
              OP_BUILD: state_r <= S_ENTER;
              OP_ADD: begin
                if (lo32 < n32 && lo32 <= top32) state_r <= S_ENTER;
                else begin
                  out_strobe_r   <= 1'b1;
                  out_found_r    <= 1'b1;
                  out_position_r <= '0;
                end
              end
              OP_SEARCH: begin
                if (lo32 < n32) state_r <= S_ENTER;
                else begin
                  out_strobe_r   <= 1'b1;
                  out_found_r    <= 1'b0;
                  out_position_r <= '0;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_LEAF: begin
          if (l_r == r_r) state_r <= S_LEAF_WR;
          else if (ql_r <= mid) begin
            k_r <= kl;
            r_r <= mid;
          end else begin
            k_r <= kr;
            l_r <= mid_p1;
          end
        end
        S_LEAF_WR: begin
          out_strobe_r   <= 1'b1;
          out_found_r    <= 1'b1;
          out_position_r <= '0;
          state_r        <= S_IDLE;
        end
        S_ENTER: begin
          unique case (op_r)
            OP_BUILD: begin
              if (l_r == r_r) state_r <= S_RET;
              else begin
                stk_r[sp_r[SIW-1:0]] <= {k_r, l_r, r_r, PH_AFTER_FIRST};
                sp_r <= sp_r + SPW'(1);
                k_r  <= kl;
                r_r  <= mid;
              end
            end
            OP_ADD: begin
              if (qr_r < l_r || r_r < ql_r) state_r <= S_RET;
              else if (ql_r <= l_r && r_r <= qr_r) begin
                // Whole node inside the range: tag it and stop here.
                ap_node_r <= k_r;
                d_r       <= amt_r;
                ap_sel_r  <= AP_TOP;
                state_r   <= S_AP_MIN;
              end else state_r <= S_PD_RD;
            end
            OP_SEARCH: begin
              if (r_r < ql_r) begin
                got_v_r <= 1'b0;
                state_r <= S_RET;
              end else state_r <= S_FIND_CHK;
            end
            default: state_r <= S_RET;
          endcase
        end
        S_FIND_CHK: begin
          if ((!q_min[VALUE_BITS-1] && q_min != '0) || q_max[VALUE_BITS-1]) begin
            got_v_r <= 1'b0;
            state_r <= S_RET;
          end else if (l_r == r_r) begin
            got_r   <= l_r;
            got_v_r <= 1'b1;
            state_r <= S_RET;
          end else state_r <= S_PD_RD;
        end
        S_PD_RD: begin
          if (q_pend == '0) state_r <= S_DESCEND;
          else begin
            d_r       <= ext_v(q_pend);
            ap_node_r <= kl;
            ap_sel_r  <= AP_LEFT;
            state_r   <= S_AP_MIN;
          end
        end
        S_AP_MIN: state_r <= S_AP_MAX;
        S_AP_MAX: state_r <= S_AP_PEND;
        S_AP_PEND: begin
          unique case (ap_sel_r)
            AP_TOP: state_r <= S_RET;
            AP_LEFT: begin
              ap_node_r <= kr;
              ap_sel_r  <= AP_RIGHT;
              state_r   <= S_AP_MIN;
            end
            AP_RIGHT: state_r <= S_PD_CLR;
            default: state_r <= S_RET;
          endcase
        end
        S_PD_CLR: state_r <= S_DESCEND;
        S_DESCEND: begin
          stk_r[sp_r[SIW-1:0]] <= {k_r, l_r, r_r, PH_AFTER_FIRST};
          sp_r <= sp_r + SPW'(1);
          // Add goes left first; the search goes right first.
          if (op_r == OP_ADD) begin
            k_r <= kl;
            r_r <= mid;
          end else begin
            k_r <= kr;
            l_r <= mid_p1;
          end
          state_r <= S_ENTER;
        end
        S_RESUME: begin
          if (op_r == OP_SEARCH) begin
            if (ph_r == PH_AFTER_SECOND || got_v_r) state_r <= S_RET;
            else begin
              stk_r[sp_r[SIW-1:0]] <= {k_r, l_r, r_r, PH_AFTER_SECOND};
              sp_r    <= sp_r + SPW'(1);
              k_r     <= kl;
              r_r     <= mid;
              state_r <= S_ENTER;
            end
          end else if (ph_r == PH_AFTER_FIRST) begin
            stk_r[sp_r[SIW-1:0]] <= {k_r, l_r, r_r, PH_AFTER_SECOND};
            sp_r    <= sp_r + SPW'(1);
            k_r     <= kr;
            l_r     <= mid_p1;
            state_r <= S_ENTER;
          end else state_r <= S_PU_A;
        end
        S_PU_A: begin
          hold_min_r <= q_min;
          hold_max_r <= q_max;
          state_r    <= S_PU_MIN;
        end
        S_PU_MIN: state_r <= S_PU_MAX;
        S_PU_MAX: state_r <= S_RET;
        S_RET: begin
          if (sp_r == '0) begin
            out_strobe_r   <= 1'b1;
            out_found_r    <= (op_r == OP_SEARCH) ? got_v_r : 1'b1;
            out_position_r <= (op_r == OP_SEARCH && got_v_r) ? 10'(got_r) : 10'd0;
            state_r        <= S_IDLE;
          end else begin
            {k_r, l_r, r_r, ph_r} <= stk_r[sp_m1[SIW-1:0]];
            sp_r    <= sp_m1;
            state_r <= S_RESUME;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/range_add_segment_tree_zero_search.sv
// Top level: APB register, node memory, shared unit and sequencer.
// Lazy segment tree with leaf write, build, saturating range add and a
// rightmost-zero search. After reset the block clears every node with busy
// high. An item is taken when start is high and busy is low; its one result
// appears for a single cycle on out_strobe and must be taken then. All steps
// share the single node memory and the one saturating add/compare unit; a
// range add or search visits roughly 4 nodes per level. Items rejected up
// front (out-of-range write or search start, empty add) answer straight from
// idle without a tree walk.
module range_add_segment_tree_zero_search #(
  parameter int MAX_ELEMENTS = rastz_pkg::DEF_MAX_ELEMENTS,
  parameter int VALUE_BITS   = rastz_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [9:0]         in_low_index,
  input  logic [9:0]         in_high_index,
  input  logic signed [15:0] in_amount,
  output logic               out_strobe,
  output logic               out_found,
  output logic [9:0]         out_position,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rastz_pkg::*;

  localparam int KW = $clog2(4 * MAX_ELEMENTS);
  localparam int AW = ((VALUE_BITS > 16) ? VALUE_BITS : 16) + 1;

  logic [SIZE_BITS-1:0]         size_r;
  seq_status_t                  status;
  logic                         rd_en;
  logic [KW-1:0]                rd_addr, wr_addr;
  mem_wen_t                     wen;
  logic signed [VALUE_BITS-1:0] wr_data, q_min, q_max, q_pend, alu_y;
  alu_op_t                      alu_op;
  logic signed [AW-1:0]         alu_a, alu_b;

  assign pready = 1'b1;
  assign busy   = status.busy;
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? {{(32-SIZE_BITS){1'b0}}, size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SIZE_IN_USE) begin
      size_r <= pwdata[SIZE_BITS-1:0];
    end
  end

  rastz_node_mem #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_BITS(VALUE_BITS)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wen     (wen),
    .wr_data (wr_data),
    .q_min   (q_min),
    .q_max   (q_max),
    .q_pend  (q_pend)
  );

  rastz_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  rastz_seq #(.MAX_ELEMENTS(MAX_ELEMENTS), .VALUE_BITS(VALUE_BITS)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_operation  (in_operation),
    .in_low_index  (in_low_index),
    .in_high_index (in_high_index),
    .in_amount     (in_amount),
    .size_cfg      (size_r),
    .status        (status),
    .out_strobe    (out_strobe),
    .out_found     (out_found),
    .out_position  (out_position),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .wen           (wen),
    .wr_data       (wr_data),
    .q_min         (q_min),
    .q_max         (q_max),
    .q_pend        (q_pend),
    .alu_op        (alu_op),
    .alu_a         (alu_a),
    .alu_b         (alu_b),
    .alu_y         (alu_y)
  );

  // A build always walks the tree, so it must hold the block busy.
  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_BUILD |=> busy)
    else $error("build did not start a tree walk");

  // Outside the clearing pass, the block only goes idle by delivering a result.
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && !$past(status.clearing) |-> out_strobe)
    else $error("walk ended without a result");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |-> out_position == 10'd0)
    else $error("nonzero position on a miss");

endmodule

### verif/range_add_segment_tree_zero_search_tb.sv
// Testbench for the range-add segment tree with rightmost-zero search.
`timescale 1ns / 1ps

module range_add_segment_tree_zero_search_tb;
  import rastz_pkg::*;

  typedef struct {
    logic       found;
    logic [9:0] position;
  } answer_t;

  // Shadow segment tree that predicts every answer and checks the block's output.
  class tree_scoreboard;
    int      node_min[4096];
    int      node_max[4096];
    int      node_pend[4096];
    int      size_reg;
    answer_t answer_q[$];
    int      errors;

    function new();
      foreach (node_pend[k]) begin
        node_pend[k] = 0;
        node_min[k]  = 0;
        node_max[k]  = 0;
      end
      size_reg = 1024;
      errors   = 0;
    endfunction

    function void set_size(int value);
      size_reg = value & 'h7FF;
    endfunction

    function int tree_size();
      if (size_reg == 0) return 1;
      if (size_reg > 1024) return 1024;
      return size_reg;
    endfunction

    function int clamp(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void shift_node(int k, int d);
      node_min[k]  = clamp(node_min[k] + d);
      node_max[k]  = clamp(node_max[k] + d);
      node_pend[k] = clamp(node_pend[k] + d);
    endfunction

    function void push_pending(int k);
      if (node_pend[k] != 0) begin
        shift_node(2 * k, node_pend[k]);
        shift_node(2 * k + 1, node_pend[k]);
        node_pend[k] = 0;
      end
    endfunction

    function void refresh(int k);
      node_min[k] = (node_min[2*k] < node_min[2*k+1]) ? node_min[2*k] : node_min[2*k+1];
      node_max[k] = (node_max[2*k] > node_max[2*k+1]) ? node_max[2*k] : node_max[2*k+1];
    endfunction

    function void rebuild(int k, int l, int r);
      int mid;
      node_pend[k] = 0;
      if (l == r) return;
      mid = (l + r) / 2;
      rebuild(2 * k, l, mid);
      rebuild(2 * k + 1, mid + 1, r);
      refresh(k);
    endfunction

    function void range_shift(int k, int l, int r, int ql, int qr, int d);
      int mid;
      if (qr < l || r < ql) return;
      if (ql <= l && r <= qr) begin
        shift_node(k, d);
        return;
      end
      push_pending(k);
      mid = (l + r) / 2;
      range_shift(2 * k, l, mid, ql, qr, d);
      range_shift(2 * k + 1, mid + 1, r, ql, qr, d);
      refresh(k);
    endfunction

    function int last_zero(int k, int l, int r, int ql);
      int mid;
      int got;
      if (r < ql) return -1;
      if (node_min[k] > 0 || node_max[k] < 0) return -1;
      if (l == r) return l;
      push_pending(k);
      mid = (l + r) / 2;
      got = last_zero(2 * k + 1, mid + 1, r, ql);
      if (got != -1) return got;
      return last_zero(2 * k, l, mid, ql);
    endfunction

    function void note_item(op_t op, int lo, int hi, int amt);
      answer_t a;
      int n;
      int k;
      int l;
      int r;
      int mid;
      int top;
      int got;
      n = tree_size();
      a.found    = 1'b1;
      a.position = '0;
      case (op)
        OP_WRITE: begin
          if (lo < n) begin
            k = 1;
            l = 0;
            r = n - 1;
            while (l != r) begin
              mid = (l + r) / 2;
              if (lo <= mid) begin
                k = 2 * k;
                r = mid;
              end else begin
                k = 2 * k + 1;
                l = mid + 1;
              end
            end
            node_min[k] = amt;
            node_max[k] = amt;
          end else begin
            a.found = 1'b0;
          end
        end
        OP_BUILD: rebuild(1, 0, n - 1);
        OP_ADD: begin
          top = (hi < n - 1) ? hi : n - 1;
          if (lo < n && lo <= top) range_shift(1, 0, n - 1, lo, top, amt);
        end
        default: begin
          got = (lo < n) ? last_zero(1, 0, n - 1, lo) : -1;
          if (got >= 0) a.position = got[9:0];
          else a.found = 1'b0;
        end
      endcase
      answer_q.push_back(a);
    endfunction

    function void check_answer(logic found, logic [9:0] position);
      answer_t a;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result found=%0d position=%0d", $time, found, position);
        errors++;
        return;
      end
      a = answer_q.pop_front();
      if (found !== a.found) begin
        $display("%0t: found expected %0d actual %0d", $time, a.found, found);
        errors++;
      end
      if (position !== a.position) begin
        $display("%0t: position expected %0d actual %0d", $time, a.position, position);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_operation;
  logic [9:0]         in_low_index;
  logic [9:0]         in_high_index;
  logic signed [15:0] in_amount;
  logic               out_strobe;
  logic               out_found;
  logic [9:0]         out_position;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  tree_scoreboard sb = new();
  int burst_left;

  range_add_segment_tree_zero_search dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // A transfer is taken when start is high and busy is low at the rising edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_item(op_t'(in_operation), in_low_index, in_high_index, in_amount);
    if (rst_n && out_strobe) sb.check_answer(out_found, out_position);
  end

  task automatic send_item(op_t op, int lo, int hi, int amt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      @(negedge clk);
      start = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    start         = 1'b1;
    in_operation  = op;
    in_low_index  = lo[9:0];
    in_high_index = hi[9:0];
    in_amount     = amt[15:0];
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(int value);
    drain();
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_SIZE_IN_USE, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_size(value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic int small_value();
    if ($urandom_range(0, 15) == 0) return $signed($urandom_range(0, 65535) - 32768);
    return $signed($urandom_range(0, 6)) - 3;
  endfunction

  // Every leaf must be written and the tree built before any add or search.
  task automatic fill_tree();
    int n;
    n = sb.tree_size();
    for (int i = 0; i < n; i++) send_item(OP_WRITE, i, 0, small_value());
    send_item(OP_BUILD, 0, 0, 0);
  endtask

  // Leaf writes only; they read no stored node, so the tree need not be filled.
  task automatic random_writes(int count);
    for (int i = 0; i < count; i++)
      send_item(OP_WRITE, $urandom_range(0, 1023), 0, small_value());
  endtask

  task automatic random_items(int count);
    int n;
    int lo;
    int hi;
    int pick;
    n = sb.tree_size();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(lo, n - 1);
      if (hi > 1023) hi = 1023;
      if (pick < 25) send_item(OP_WRITE, lo, $urandom_range(0, 1023), small_value());
      else if (pick < 32) send_item(OP_BUILD, lo, hi, small_value());
      else if (pick < 65) send_item(OP_ADD, lo, hi, small_value());
      else send_item(OP_SEARCH, lo, hi, small_value());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_WRITE;
    in_low_index  = '0;
    in_high_index = '0;
    in_amount     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    burst_left    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, saturation, ignored writes, empty and clipped adds.
    write_size(4);
    send_item(OP_WRITE, 0, 0, 0);
    send_item(OP_WRITE, 1, 1023, 32767);
    send_item(OP_WRITE, 2, 0, -32768);
    send_item(OP_WRITE, 3, 0, 0);
    send_item(OP_WRITE, 4, 0, 5);
    send_item(OP_WRITE, 1023, 1023, -1);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_SEARCH, 0, 0, 0);
    send_item(OP_SEARCH, 3, 0, 0);
    send_item(OP_SEARCH, 1023, 1023, 0);
    send_item(OP_ADD, 0, 1023, 32767);
    send_item(OP_ADD, 0, 3, -32768);
    send_item(OP_ADD, 3, 1, 7);
    send_item(OP_ADD, 4, 1023, 7);
    send_item(OP_ADD, 1, 2, 1);
    send_item(OP_SEARCH, 0, 0, 0);
    send_item(OP_WRITE, 2, 0, 0);
    send_item(OP_SEARCH, 1, 0, 0);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_SEARCH, 0, 0, 0);
    random_items(60);

    // Size zero acts as one; writing one afterwards keeps the same shape.
    write_size(0);
    fill_tree();
    random_items(40);
    write_size(1);
    random_items(30);

    // Oversized value acts as the maximum, so the last index is a valid leaf.
    write_size(2047);
    send_item(OP_WRITE, 1023, 0, 3);
    random_writes(20);
    write_size(1024);
    send_item(OP_WRITE, 1023, 0, -3);
    random_writes(20);

    for (int p = 0; p < 6; p++) begin
      write_size($urandom_range(2, 48));
      fill_tree();
      random_items(90);
    end
    write_size(2);
    fill_tree();
    random_items(60);

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule
